/* src/zrl_pkg.sv */
// Shared types and constants for the zero/0xFF run-length codec.
// No dependencies; every other file imports this package.
`default_nettype none

package zrl_pkg;

  localparam int unsigned MaxRes   = 4;
  localparam int unsigned ResIdxW  = $clog2(MaxRes);
  localparam int unsigned ResCntW  = $clog2(MaxRes + 1);
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [7:0] ByteZero  = 8'h00;
  localparam logic [7:0] ByteOnes  = 8'hFF;
  localparam logic [7:0] RunMax    = 8'd255;
  localparam logic [7:0] RepOne    = 8'd1;

  typedef enum logic {
    MODE_COMPRESS   = 1'b0,
    MODE_DECOMPRESS = 1'b1
  } mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] repeat_res;
    logic       item_last;
    logic       stream_done;
  } out_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] rep;
  } result_t;

  // One input's worth of results, produced by the front and expanded by the back.
  typedef struct packed {
    result_t [MaxRes-1:0] res;
    logic [ResIdxW-1:0]   last_idx;
    logic                 done;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic not_empty;
    logic full;
    cmd_t cmd;
  } q_status_t;

endpackage

`default_nettype wire

/* src/zrl_front.sv */
// Front end: holds the mode register and run state, classifies each input
// and builds the list of results it causes. Depends on zrl_pkg.
`default_nettype none

module zrl_front import zrl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  input  logic     q_full_i,
  output push_t    push_o
);

  mode_e      mode_q;
  logic [7:0] run_count_q, run_count_d;
  logic       run_is_ff_q, run_is_ff_d;
  logic       marker_pending_q, marker_pending_d;

  logic       accept;
  logic       is_mark, kind, flush_a, sat, end_flush, kind_new;
  logic [7:0] b, cnt0, cnt1, cnt2, mk_old, mk_new;
  result_t [MaxRes-1:0] res;
  logic [ResCntW-1:0]   n;

  assign accept = in_valid_i && !q_full_i;

  always_comb begin
    b         = in_item_i.in_byte;
    is_mark   = (b == ByteZero) || (b == ByteOnes);
    kind      = (b == ByteOnes);
    mk_old    = run_is_ff_q ? ByteOnes : ByteZero;
    res       = '0;
    n         = '0;
    flush_a   = 1'b0;
    sat       = 1'b0;
    end_flush = 1'b0;
    cnt0      = run_count_q;
    cnt1      = run_count_q;
    cnt2      = run_count_q;
    kind_new  = run_is_ff_q;
    mk_new    = mk_old;
    run_count_d      = run_count_q;
    run_is_ff_d      = run_is_ff_q;
    marker_pending_d = marker_pending_q;

    unique case (mode_q)
      MODE_COMPRESS: begin
        flush_a = (run_count_q != 8'd0) && (!is_mark || (kind != run_is_ff_q));
        if (flush_a) begin
          res[n[ResIdxW-1:0]] = '{value: mk_old, rep: RepOne};
          n = n + 1'b1;
          res[n[ResIdxW-1:0]] = '{value: run_count_q, rep: RepOne};
          n = n + 1'b1;
        end
        cnt0 = flush_a ? 8'd0 : run_count_q;
        if (is_mark) begin
          kind_new = (cnt0 == 8'd0) ? kind : run_is_ff_q;
          mk_new   = kind_new ? ByteOnes : ByteZero;
          cnt1     = cnt0 + 8'd1;
          sat      = (cnt1 == RunMax);
          if (sat) begin
            res[n[ResIdxW-1:0]] = '{value: mk_new, rep: RepOne};
            n = n + 1'b1;
            res[n[ResIdxW-1:0]] = '{value: RunMax, rep: RepOne};
            n = n + 1'b1;
          end
          cnt2 = sat ? 8'd0 : cnt1;
        end else begin
          res[n[ResIdxW-1:0]] = '{value: b, rep: RepOne};
          n = n + 1'b1;
          cnt2 = 8'd0;
        end
        end_flush = in_item_i.stream_end && (cnt2 != 8'd0);
        if (end_flush) begin
          res[n[ResIdxW-1:0]] = '{value: mk_new, rep: RepOne};
          n = n + 1'b1;
          res[n[ResIdxW-1:0]] = '{value: cnt2, rep: RepOne};
          n = n + 1'b1;
        end
        run_count_d = cnt2;
        run_is_ff_d = kind_new;
      end
      MODE_DECOMPRESS: begin
        if (marker_pending_q) begin
          res[n[ResIdxW-1:0]] = '{value: mk_old, rep: b};
          n = n + 1'b1;
          marker_pending_d = 1'b0;
        end else if (is_mark) begin
          marker_pending_d = 1'b1;
          run_is_ff_d      = kind;
        end else begin
          res[n[ResIdxW-1:0]] = '{value: b, rep: RepOne};
          n = n + 1'b1;
        end
        // A marker left dangling at the end of the stream stands for one byte.
        if (in_item_i.stream_end && marker_pending_d) begin
          res[n[ResIdxW-1:0]] = '{value: (kind ? ByteOnes : ByteZero), rep: RepOne};
          n = n + 1'b1;
        end
      end
      default: begin
        n = '0;
      end
    endcase

    // An end input with nothing else to say still reports the stream end.
    if (in_item_i.stream_end && (n == '0)) begin
      res[0] = '{value: ByteZero, rep: 8'd0};
      n = n + 1'b1;
    end

    if (in_item_i.stream_end) begin
      run_count_d      = 8'd0;
      run_is_ff_d      = 1'b0;
      marker_pending_d = 1'b0;
    end
  end

  always_comb begin
    push_o.valid        = accept && (n != '0);
    push_o.cmd.res      = res;
    push_o.cmd.last_idx = ResIdxW'(n - 1'b1);
    push_o.cmd.done     = in_item_i.stream_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q           <= MODE_COMPRESS;
      run_count_q      <= 8'd0;
      run_is_ff_q      <= 1'b0;
      marker_pending_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q           <= mode_e'(cfg_wdata_i);
      run_count_q      <= 8'd0;
      run_is_ff_q      <= 1'b0;
      marker_pending_q <= 1'b0;
    end else if (accept) begin
      run_count_q      <= run_count_d;
      run_is_ff_q      <= run_is_ff_d;
      marker_pending_q <= marker_pending_d;
    end
  end

endmodule

`default_nettype wire

/* src/zrl_queue.sv */
// Two-entry command queue between the front and back ends.
// Depends on zrl_pkg for the command type.
`default_nettype none

module zrl_queue import zrl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  input  logic      pop_i,
  output q_status_t status_o
);

  cmd_t [QDepth-1:0] mem_q;
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q;

  always_comb begin
    status_o.not_empty = (count_q != '0);
    status_o.full      = (count_q == QCntW'(QDepth));
    status_o.cmd       = mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i.valid, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/zrl_back.sv */
// Back end: walks the head command one result per cycle, while the output is not
// stalled, into the output register. Depends on zrl_pkg.
`default_nettype none

module zrl_back import zrl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t status_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic [ResIdxW-1:0] idx_q;
  logic               out_valid_q;
  out_item_t          out_q;
  logic               load, is_last;
  result_t            cur;

  assign load    = status_i.not_empty && (!out_valid_q || !out_stall_i);
  assign is_last = (idx_q == status_i.cmd.last_idx);
  assign cur     = status_i.cmd.res[idx_q];
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_byte    <= cur.value;
      out_q.repeat_res  <= cur.rep;
      out_q.item_last   <= is_last;
      out_q.stream_done <= is_last && status_i.cmd.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= status_i.not_empty;
      end
      if (load) begin
        idx_q <= is_last ? '0 : idx_q + 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* src/zero_ff_run_length_codec.sv */
// An accepted input transaction is written into the command queue; its results are then
// loaded one at a time from the queue head into the output register, where they are taken.
// Throughput: an input causes 1 to 4 results, which the back end's output register hands
// out at one result per cycle while out_stall_i is low; an input causing none is dropped.
// The front accepts a transaction every cycle while the two-entry command queue has room.
// Reset (rst_ni low, asynchronous) selects compress mode, clears run state and empties
// the queue and output register. Depends on zrl_pkg, zrl_front, zrl_queue, zrl_back.
`default_nettype none

module zero_ff_run_length_codec import zrl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  // Mode register write port.
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  // Input channel.
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  // Output channel.
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // The front end turns each accepted transaction into one command holding
  // every result that transaction causes. Commands with no results (a run
  // still growing, or a marker awaiting its count) are dropped at the front.
  push_t     push;
  q_status_t q_status;
  logic      pop;

  // The input stalls only when the command queue is full, which depends
  // on registered state alone, never on in_valid_i.
  assign in_stall_o = q_status.full;

  zrl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .q_full_i    (q_status.full),
    .push_o      (push)
  );

  // The queue decouples the two sides so a stalled output does not stop
  // the front from taking more input until both entries are used.
  zrl_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .status_o (q_status)
  );

  // The back end steps through the head command, one result per cycle while the output
  // is not stalled, and pops it once its last result has been loaded into the output.
  zrl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .status_i    (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

/* src/zrl_checker.sv */
// Port-level checks for the codec, attached to the top level by a bind.
// Depends on zrl_pkg and the zero_ff_run_length_codec port list.
`default_nettype none

module zrl_checker import zrl_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output changed");

  // The end of the stream is always the last result of its input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.stream_done |-> out_item_o.item_last)
    else $error("stream_done without item_last");

  // A zero repeat count only ever comes with a marker value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.repeat_res == 8'd0) |->
      (out_item_o.out_byte == ByteZero) || (out_item_o.out_byte == ByteOnes))
    else $error("zero repeat on a non-marker byte");

  // Coming out of reset the block is empty and takes input at once.
  assert property (@(posedge clk_i)
    !$past(rst_ni) && rst_ni |-> !in_stall_o && !out_valid_o)
    else $error("block not empty after reset");

endmodule

bind zero_ff_run_length_codec zrl_checker u_zrl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the zero/0xFF run-length codec, in both compress and
// decompress mode, with random gaps and stalls on both channels.
// Depends on zrl_pkg and the zero_ff_run_length_codec top level.
`default_nettype none

module testbench;
  import zrl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Clock, reset and every input of the block start at known values.
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_wdata_i = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  zero_ff_run_length_codec i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bytes waiting to be offered to the block, and the results that the accepted
  // bytes are predicted to produce, oldest first.
  in_item_t  bytes_to_send[$];
  out_item_t results_due[$];
  out_item_t step_results[$];
  int        n_queued = 0;
  int        n_errors = 0;

  // Handshake bookkeeping. The rising-edge process records whether a transaction
  // took place; the falling-edge drivers act on that record.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  int   send_wait = 0;
  int   recv_wait = 0;
  bit   send_burst = 1'b0;
  bit   recv_burst = 1'b0;

  // Predictor state: the selected mode, the length and kind of the open run in
  // compress mode, and whether decompress mode has seen a marker without its count.
  mode_e      cur_mode    = MODE_COMPRESS;
  logic [7:0] run_len     = '0;
  logic       run_ff      = 1'b0;
  logic       marker_seen = 1'b0;

  function automatic void clear_stream_state();
    run_len     = '0;
    run_ff      = 1'b0;
    marker_seen = 1'b0;
  endfunction

  function automatic void add_result(logic [7:0] value, logic [7:0] rep);
    out_item_t r;
    r.out_byte    = value;
    r.repeat_res  = rep;
    r.item_last   = 1'b0;
    r.stream_done = 1'b0;
    step_results.push_back(r);
  endfunction

  // A closed run leaves as its marker byte followed by its length.
  function automatic void close_run();
    add_result(run_ff ? ByteOnes : ByteZero, RepOne);
    add_result(run_len, RepOne);
    run_len = '0;
  endfunction

  // Works out the results that one accepted byte causes and queues them.
  function automatic void code_byte(in_item_t it);
    logic       is_mark;
    logic       is_ff;
    int         last;
    is_mark = (it.in_byte == ByteZero) || (it.in_byte == ByteOnes);
    is_ff   = (it.in_byte == ByteOnes);
    step_results.delete();
    if (cur_mode == MODE_COMPRESS) begin
      // A literal or a marker of the other kind ends the open run first.
      if (run_len != 0 && (!is_mark || is_ff != run_ff)) close_run();
      if (is_mark) begin
        if (run_len == 0) run_ff = is_ff;
        run_len = run_len + 8'd1;
        // A run that reaches the largest count is flushed at once.
        if (run_len == RunMax) close_run();
      end else begin
        add_result(it.in_byte, RepOne);
      end
      if (it.stream_end && run_len != 0) close_run();
    end else begin
      if (marker_seen) begin
        // This byte is the count that belongs to the pending marker.
        add_result(run_ff ? ByteOnes : ByteZero, it.in_byte);
        marker_seen = 1'b0;
      end else if (is_mark) begin
        marker_seen = 1'b1;
        run_ff      = is_ff;
      end else begin
        add_result(it.in_byte, RepOne);
      end
      // A marker left without its count at the end of the stream stands for one byte.
      if (it.stream_end && marker_seen) begin
        add_result(run_ff ? ByteOnes : ByteZero, RepOne);
        marker_seen = 1'b0;
      end
    end
    if (it.stream_end) begin
      if (step_results.size() == 0) add_result(ByteZero, 8'd0);
      last = step_results.size() - 1;
      step_results[last].stream_done = 1'b1;
      clear_stream_state();
    end
    if (step_results.size() != 0) begin
      last = step_results.size() - 1;
      step_results[last].item_last = 1'b1;
    end
    foreach (step_results[i]) results_due.push_back(step_results[i]);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%02h, actual 0x%02h", name, want, got);
      n_errors++;
    end
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (results_due.size() == 0) begin
      $error("result with no expectation: out_byte 0x%02h repeat_res %0d",
             got.out_byte, got.repeat_res);
      n_errors++;
    end else begin
      want = results_due.pop_front();
      check_field("out_byte", want.out_byte, got.out_byte);
      check_field("repeat_res", want.repeat_res, got.repeat_res);
      check_field("item_last", 8'(want.item_last), 8'(got.item_last));
      check_field("stream_done", 8'(want.stream_done), 8'(got.stream_done));
    end
  endfunction

  // Monitor: at each rising edge, an accepted input transaction is predicted before
  // an accepted output transaction is checked, so a result is never compared with
  // an expectation that does not exist yet.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken  <= in_valid_i && !in_stall_o;
      out_taken <= out_valid_o && !out_stall_i;
      if (in_valid_i && !in_stall_o) code_byte(in_item_i);
      if (out_valid_o && !out_stall_i) check_result(out_item_o);
    end
  end

  // Input driver. A stalled byte is held unchanged. Otherwise the driver either idles
  // for the wait drawn with the previous byte or offers the next one; valid is
  // assigned once per falling edge, so back-to-back bytes keep it high.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      in_valid_i <= 1'b1;
    end else if (send_wait > 0) begin
      in_valid_i <= 1'b0;
      send_wait--;
    end else if (bytes_to_send.size() != 0) begin
      in_item_i  <= bytes_to_send.pop_front();
      in_valid_i <= 1'b1;
      send_wait = send_burst ? 0 : $urandom_range(0, 3);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Output driver. After each accepted result the receiver stalls for a fresh number
  // of cycles, so stalls land on every phase of the block's work.
  always @(negedge clk_i) begin
    if (out_taken) recv_wait = recv_burst ? 0 : $urandom_range(0, 3);
    if (recv_wait > 0) begin
      out_stall_i <= 1'b1;
      recv_wait--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic push_byte(logic [7:0] value, logic last_of_stream);
    in_item_t it;
    it.in_byte    = value;
    it.stream_end = last_of_stream;
    bytes_to_send.push_back(it);
    n_queued++;
  endtask

  // Waits until every byte is accepted and every expected result has arrived, then
  // lets a few more cycles pass for bytes that produce no result.
  task automatic wait_idle();
    while (bytes_to_send.size() != 0 || in_valid_i || results_due.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // The mode register is only written while the block is idle. A write also drops
  // any open run or pending marker.
  task automatic write_mode(mode_e m);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_mode = m;
    clear_stream_state();
  endtask

  // Random raw stream: mostly runs of 0x00 or 0xFF between literals, with random
  // bytes and stream ends mixed in. A long run optionally goes first so that the
  // run counter saturates.
  task automatic gen_raw_stream(int n_items, bit with_long_run);
    int         left;
    int         len;
    int         pick;
    logic [7:0] mark;
    left = n_items;
    if (with_long_run) begin
      mark = $urandom_range(0, 1) ? ByteOnes : ByteZero;
      len  = $urandom_range(255, 262);
      repeat (len - 1) push_byte(mark, 1'b0);
      push_byte(mark, 1'($urandom_range(0, 1)));
    end
    while (left > 0) begin
      pick = $urandom_range(0, 9);
      mark = $urandom_range(0, 1) ? ByteOnes : ByteZero;
      if (pick < 4) begin
        len = $urandom_range(1, 6);
        repeat (len) push_byte(mark, 1'b0);
        left -= len;
      end else if (pick < 7) begin
        push_byte(8'($urandom_range(1, 254)), 1'b0);
        left--;
      end else if (pick < 8) begin
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        left--;
      end else begin
        // End of stream, half the time on a marker byte that closes an open run.
        push_byte($urandom_range(0, 1) ? mark : 8'($urandom_range(0, 255)), 1'b1);
        left--;
      end
    end
  endtask

  // Random coded stream: mostly well-formed marker and count pairs and literals;
  // the rest are dangling markers, stray bytes and stream ends.
  task automatic gen_coded_stream(int n_items);
    int         left;
    int         pick;
    logic [7:0] mark;
    left = n_items;
    while (left > 0) begin
      pick = $urandom_range(0, 9);
      mark = $urandom_range(0, 1) ? ByteOnes : ByteZero;
      if (pick < 4) begin
        push_byte(mark, 1'b0);
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        left -= 2;
      end else if (pick < 7) begin
        push_byte(8'($urandom_range(1, 254)), $urandom_range(0, 9) == 0);
        left--;
      end else if (pick < 8) begin
        push_byte(mark, 1'b1);
        left--;
      end else begin
        push_byte(8'($urandom_range(0, 255)), pick == 9);
        left--;
      end
    end
  endtask

  initial begin
    int phase;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed compress: a literal, runs ended by a literal, by the other kind and
    // by the stream end, an end on a literal, and an input that yields four results.
    write_mode(MODE_COMPRESS);
    push_byte(8'h41, 1'b0);
    push_byte(ByteZero, 1'b0);
    push_byte(ByteZero, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(ByteOnes, 1'b0);
    push_byte(ByteOnes, 1'b0);
    push_byte(ByteZero, 1'b0);
    push_byte(ByteZero, 1'b1);
    push_byte(8'h80, 1'b1);
    push_byte(ByteOnes, 1'b0);
    push_byte(ByteZero, 1'b1);
    push_byte(ByteZero, 1'b0);
    push_byte(8'h01, 1'b1);
    push_byte(ByteOnes, 1'b1);
    wait_idle();

    // Directed decompress: a literal, pairs with counts of 5, 0 and 255, a count that
    // ends the stream, a dangling marker and a literal that ends the stream.
    write_mode(MODE_DECOMPRESS);
    push_byte(8'hFE, 1'b0);
    push_byte(ByteZero, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(ByteOnes, 1'b0);
    push_byte(ByteZero, 1'b0);
    push_byte(ByteOnes, 1'b0);
    push_byte(ByteOnes, 1'b0);
    push_byte(ByteZero, 1'b0);
    push_byte(ByteZero, 1'b1);
    push_byte(ByteOnes, 1'b1);
    push_byte(8'h7E, 1'b1);
    wait_idle();

    // Random phases alternate the mode. A phase may end inside a run or after a
    // bare marker, so the next mode write has to discard that state. Some phases
    // run without any gaps or stalls on one or both sides.
    phase = 0;
    while (n_queued < 480) begin
      send_burst = ($urandom_range(0, 2) == 0);
      recv_burst = ($urandom_range(0, 2) == 0);
      if (phase % 2 == 0) begin
        write_mode(MODE_COMPRESS);
        gen_raw_stream(50, phase == 0);
      end else begin
        write_mode(MODE_DECOMPRESS);
        gen_coded_stream(30);
        // Once, the sender holds off until the block has delivered everything.
        if (phase == 1) wait_idle();
        gen_coded_stream(30);
      end
      wait_idle();
      phase++;
    end

    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
